>>> hdl/sha1_pkg.sv
// Shared types and constants for the SHA-1 byte stream hash.
package sha1_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND        = 2'd0,
        CMD_APPEND_FINISH = 2'd1,
        CMD_FINISH        = 2'd2,
        CMD_UNUSED        = 2'd3
    } cmd_t;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] IDX_MASK  = 6'h3F;
    localparam int         QDEPTH    = 4;
    localparam int         QAW       = 2;

    // Classified operation handed from front to back
    typedef struct packed {
        logic       has_byte;
        logic       finish;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } res_t;

endpackage

>>> hdl/sha1_if.sv
// Valid/ready channel interfaces for input items and digest words.
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    modport source (output valid, cmd, data_byte, input ready);
    modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> hdl/sha1_front.sv
// Front end: accepts input items, drops unused commands, queues operations.
module sha1_front (
    input  logic         clk,
    input  logic         rst_n,
    sha1_in_if.sink      in_ch,
    output sha1_pkg::op_t q_op,
    output logic         q_valid,
    input  logic         q_pop
);
    import sha1_pkg::*;

    op_t            mem_reg [QDEPTH];
    logic [QAW-1:0] wr_reg, rd_reg;
    logic [QAW:0]   cnt_reg;
    logic           push;
    op_t            op_in;

    assign in_ch.ready = (cnt_reg != (QAW+1)'(QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;

    // Classify the command
    always_comb
    begin
        op_in.data     = in_ch.data_byte;
        op_in.has_byte = (in_ch.cmd == CMD_APPEND) || (in_ch.cmd == CMD_APPEND_FINISH);
        op_in.finish   = (in_ch.cmd == CMD_APPEND_FINISH) || (in_ch.cmd == CMD_FINISH);
    end

    always_ff @(posedge clk)
    begin
        if (push && (op_in.has_byte || op_in.finish))
            mem_reg[wr_reg] <= op_in;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            logic do_push;
            do_push = push && (op_in.has_byte || op_in.finish);
            if (do_push)
                wr_reg <= wr_reg + QAW'(1);
            if (q_pop)
                rd_reg <= rd_reg + QAW'(1);
            cnt_reg <= cnt_reg + (QAW+1)'(do_push) - (QAW+1)'(q_pop);
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_op    = mem_reg[rd_reg];

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAW+1)'(QDEPTH)) else $error("queue overflow");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
`endif
endmodule

>>> hdl/sha1_core.sv
// Back end: block store, padding sequencer, 80-round compression, digest out.
module sha1_core (
    input  logic          clk,
    input  logic          rst_n,
    input  sha1_pkg::op_t q_op,
    input  logic          q_valid,
    output logic          q_pop,
    sha1_out_if.source    out_ch
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_ROUND, S_ADD, S_OUT
    } state_t;

    state_t        state_reg;
    logic [31:0]   w_reg [16];      // block store as words, also rolling schedule
    logic [31:0]   h_reg [5];
    logic [31:0]   a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [60:0]   cnt_reg;
    logic [5:0]    pidx_reg;        // padding write index
    logic [6:0]    rnd_reg;
    logic          fin_reg;         // finishing: after compress go to pad/out
    logic          lenblk_reg;      // pad byte placed: spill or length block under way
    logic [2:0]    oidx_reg;
    logic [63:0]   bits;

    assign bits = {cnt_reg, 3'b000};

    // Round datapath
    logic [31:0] wx, f, k, t;
    logic [3:0]  ri;
    always_comb
    begin
        ri = rnd_reg[3:0];
        if (rnd_reg < 7'd16)
            wx = w_reg[ri];
        else
        begin
            wx = w_reg[ri + 4'd13] ^ w_reg[ri + 4'd8] ^ w_reg[ri + 4'd2] ^ w_reg[ri];
            wx = {wx[30:0], wx[31]};
        end
        if (rnd_reg < 7'd20)
        begin
            f = d_reg ^ (b_reg & (c_reg ^ d_reg)); k = K_0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg; k = K_1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (d_reg & (b_reg | c_reg)); k = K_2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg; k = K_3;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wx;
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.digest_word = h_reg[oidx_reg];
    assign out_ch.word_index  = oidx_reg;
    assign out_ch.last_word   = (oidx_reg == 3'd4);

    // Write one byte into the word-organised store
    function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] lane, logic [7:0] v);
        logic [31:0] r;
        r = w;
        case (lane)
            2'd0:    r[31:24] = v;
            2'd1:    r[23:16] = v;
            2'd2:    r[15:8]  = v;
            default: r[7:0]   = v;
        endcase
        return r;
    endfunction

    // Payload: store, schedule, working variables
    always_ff @(posedge clk)
    begin
        logic [5:0] bi;
        bi = cnt_reg[5:0];
        case (state_reg)
            S_IDLE:
                if (q_pop && q_op.has_byte)
                    w_reg[bi[5:2]] <= put_byte(w_reg[bi[5:2]], bi[1:0], q_op.data);
            S_PAD:
                w_reg[pidx_reg[5:2]] <= put_byte(w_reg[pidx_reg[5:2]], pidx_reg[1:0],
                    (pidx_reg == cnt_reg[5:0] && !lenblk_reg) ? PAD_BYTE : 8'h00);
            S_LEN:
            begin
                w_reg[14] <= bits[63:32];
                w_reg[15] <= bits[31:0];
                a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                d_reg <= h_reg[3]; e_reg <= h_reg[4];
            end
            S_ROUND:
            begin
                if (rnd_reg >= 7'd16)
                    w_reg[ri] <= wx;
                a_reg <= t; b_reg <= a_reg; c_reg <= {b_reg[1:0], b_reg[31:2]};
                d_reg <= c_reg; e_reg <= d_reg;
            end
            default: ;
        endcase
        // Full data block: load working variables for compression
        if (state_reg == S_IDLE && q_pop && q_op.has_byte && bi == IDX_MASK)
        begin
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
            d_reg <= h_reg[3]; e_reg <= h_reg[4];
        end
        if (state_reg == S_PAD && pidx_reg == IDX_MASK && !lenblk_reg)
        begin
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
            d_reg <= h_reg[3]; e_reg <= h_reg[4];
        end
    end

    // Control state and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT; h_reg[2] <= H2_INIT;
            h_reg[3] <= H3_INIT; h_reg[4] <= H4_INIT;
            cnt_reg    <= '0;
            pidx_reg   <= '0;
            rnd_reg    <= '0;
            fin_reg    <= 1'b0;
            lenblk_reg <= 1'b0;
            oidx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (q_pop)
                    begin
                        logic [60:0] nc;
                        nc = q_op.has_byte ? cnt_reg + 61'd1 : cnt_reg;
                        cnt_reg    <= nc;
                        fin_reg    <= q_op.finish;
                        lenblk_reg <= 1'b0;
                        rnd_reg    <= '0;
                        if (q_op.has_byte && nc[5:0] == 6'd0)
                            state_reg <= S_ROUND;
                        else if (q_op.finish)
                        begin
                            pidx_reg  <= nc[5:0];
                            state_reg <= S_PAD;
                        end
                    end
                S_PAD:
                begin
                    // Fill up to 56 (length fits) or 64 (spill block)
                    if (pidx_reg == 6'd55 && (cnt_reg[5:0] < 6'd56 || lenblk_reg))
                        state_reg <= S_LEN;
                    else if (pidx_reg == IDX_MASK)
                    begin
                        lenblk_reg <= 1'b1;
                        rnd_reg    <= '0;
                        state_reg  <= S_ROUND;
                    end
                    pidx_reg <= pidx_reg + 6'd1;
                end
                S_LEN:
                begin
                    lenblk_reg <= 1'b1;
                    rnd_reg    <= '0;
                    state_reg  <= S_ROUND;
                end
                S_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd79)
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    if (!fin_reg)
                        state_reg <= S_IDLE;
                    else if (lenblk_reg && pidx_reg == 6'd56)
                    begin
                        oidx_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        // data block finished at finish, or spill block done
                        pidx_reg  <= lenblk_reg ? 6'd0 : cnt_reg[5:0];
                        state_reg <= S_PAD;
                    end
                end
                S_OUT:
                    if (out_ch.ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd4)
                        begin
                            h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT;
                            h_reg[2] <= H2_INIT; h_reg[3] <= H3_INIT;
                            h_reg[4] <= H4_INIT;
                            cnt_reg   <= '0;
                            fin_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> oidx_reg <= 3'd4) else $error("digest index out of range");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE) else $error("pop while busy");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND |-> rnd_reg < 7'd80) else $error("round overrun");
`endif
endmodule

>>> hdl/sha1_byte_stream_hash.sv
// Top level of the SHA-1 byte stream hash.
// SHA-1 over a byte stream. Bytes enter a four-entry queue and are stored by the back
// end; every 64th byte starts the 80-round compression plus chaining add in the
// single round unit, which sets the sustained rate. The queue takes further bytes while
// the compression runs, until it is full. A finish adds up to two padding sweeps and
// compressions, then five digest transfers, H0 first, with last_word on H4.
// Command 3 is accepted and discarded.
module sha1_byte_stream_hash (
    input logic       clk,
    input logic       rst_n,
    sha1_in_if.sink   in_ch,
    sha1_out_if.source out_ch
);
    import sha1_pkg::*;

    op_t  q_op;
    logic q_valid, q_pop;

    sha1_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_op(q_op), .q_valid(q_valid), .q_pop(q_pop)
    );

    sha1_core u_core (
        .clk(clk), .rst_n(rst_n), .q_op(q_op), .q_valid(q_valid),
        .q_pop(q_pop), .out_ch(out_ch)
    );
endmodule

>>> tb/tb_sha1_byte_stream_hash.sv
// Testbench for the SHA-1 byte stream hash: directed and random messages, local predictor.
`timescale 1ns / 100ps
module tb_sha1_byte_stream_hash;
    import sha1_pkg::*;

    logic clk;
    logic rst_n;

    sha1_in_if  in_ch ();
    sha1_out_if out_ch ();

    sha1_byte_stream_hash u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Predictor state
    logic [31:0] hash_h [5];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_len;

    res_t        digest_q [$];
    int          error_cnt;
    int          item_cnt;
    int          digest_cnt;
    int          msg_cnt;
    longint      cycle_cnt;
    bit          rx_idle_en;
    int          rx_wait;

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 2000000)
        begin
            $display("tb_sha1_byte_stream_hash: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // One 80-round compression of msg_block into hash_h
    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 16)
                x = w[i];
            else
            begin
                x = rotl(w[(i-3)&15] ^ w[(i-8)&15] ^ w[(i-14)&15] ^ w[i&15], 1);
                w[i&15] = x;
            end
            if (i < 20)      begin f = d ^ (b & (c ^ d));          k = K_0; end
            else if (i < 40) begin f = b ^ c ^ d;                  k = K_1; end
            else if (i < 60) begin f = (b & c) | (d & (b | c));    k = K_2; end
            else             begin f = b ^ c ^ d;                  k = K_3; end
            t = rotl(a, 5) + f + e + k + x;
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
    endtask

    task automatic hash_init();
        hash_h[0] = H0_INIT; hash_h[1] = H1_INIT; hash_h[2] = H2_INIT;
        hash_h[3] = H3_INIT; hash_h[4] = H4_INIT;
        msg_len = '0;
    endtask

    task automatic hash_add_byte(input logic [7:0] v);
        msg_block[msg_len[5:0]] = v;
        msg_len = msg_len + 61'd1;
        if (msg_len[5:0] == 6'd0)
            compress_block();
    endtask

    // Padding, length and digest queueing
    task automatic hash_finish();
        logic [63:0] bits;
        int idx;
        res_t r;
        bits = {msg_len, 3'b000};
        idx = msg_len[5:0];
        msg_block[idx] = PAD_BYTE;
        idx++;
        if (idx > 56)
        begin
            while (idx < 64) msg_block[idx++] = 8'h00;
            compress_block();
            idx = 0;
        end
        while (idx < 56) msg_block[idx++] = 8'h00;
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = bits[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 5; i++)
        begin
            r.digest_word = hash_h[i];
            r.word_index  = 3'(i);
            r.last_word   = (i == 4);
            digest_q.push_back(r);
        end
        hash_init();
        msg_cnt++;
    endtask

    // Send one item after a random gap; predict on acceptance
    task automatic send_item(input cmd_t cmd, input logic [7:0] data, input bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.data_byte <= data;
        do @(posedge clk); while (!in_ch.ready);
        item_cnt++;
        case (cmd)
            CMD_APPEND:        hash_add_byte(data);
            CMD_APPEND_FINISH: begin hash_add_byte(data); hash_finish(); end
            CMD_FINISH:        hash_finish();
            default:           ;
        endcase
    endtask

    task automatic drop_valid();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver stalls: a random wait drawn after every accepted digest word while rx_idle_en is set
    always @(posedge clk or negedge rst_n)
    begin
        int w;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_wait      <= 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            w = rx_idle_en ? $urandom_range(0, 9) : 0;
            rx_wait      <= w;
            out_ch.ready <= (w == 0);
        end
        else if (!out_ch.ready)
        begin
            if (rx_wait <= 1)
                out_ch.ready <= 1'b1;
            rx_wait <= rx_wait - 1;
        end
    end

    // Digest checker
    always @(posedge clk)
    begin
        res_t exp;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            digest_cnt++;
            if (digest_q.size() == 0)
            begin
                error_cnt++;
                $display("%0t: unexpected digest word %h idx %0d", $time,
                         out_ch.digest_word, out_ch.word_index);
            end
            else
            begin
                exp = digest_q.pop_front();
                if (out_ch.digest_word !== exp.digest_word)
                begin
                    error_cnt++;
                    $display("%0t: digest_word exp %h got %h", $time,
                             exp.digest_word, out_ch.digest_word);
                end
                if (out_ch.word_index !== exp.word_index)
                begin
                    error_cnt++;
                    $display("%0t: word_index exp %0d got %0d", $time,
                             exp.word_index, out_ch.word_index);
                end
                if (out_ch.last_word !== exp.last_word)
                begin
                    error_cnt++;
                    $display("%0t: last_word exp %0b got %0b", $time,
                             exp.last_word, out_ch.last_word);
                end
            end
        end
    end

    // Empty message, single bytes, byte extremes, unused command
    task automatic test_short_messages();
        send_item(CMD_FINISH, 8'hFF);
        send_item(CMD_APPEND_FINISH, 8'h00);
        send_item(CMD_APPEND_FINISH, 8'hFF);
        send_item(CMD_UNUSED, 8'hA5);
        send_item(CMD_APPEND, 8'h61);
        send_item(CMD_APPEND, 8'h62);
        send_item(CMD_UNUSED, 8'h5A);
        send_item(CMD_APPEND_FINISH, 8'h63);
        drop_valid();
    endtask

    // Padding spill: 55, 56 and 64 bytes, back to back
    task automatic test_block_edges();
        int lens [3] = '{55, 56, 64};
        foreach (lens[j])
        begin
            for (int i = 0; i < lens[j]; i++)
                send_item(CMD_APPEND, 8'($urandom), 0);
            send_item(CMD_FINISH, 8'h00, 0);
        end
        drop_valid();
    endtask

    // Random messages, mostly short, some over several blocks
    task automatic test_random_messages();
        int len;
        int sent;
        logic [1:0] c;
        sent = 0;
        while (sent < 310)
        begin
            rx_idle_en = ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 140)
                                               : $urandom_range(0, 20);
            for (int i = 0; i < len; i++)
            begin
                c = ($urandom_range(0, 15) == 0) ? CMD_UNUSED : CMD_APPEND;
                send_item(cmd_t'(c), 8'($urandom));
                sent++;
            end
            if ($urandom_range(0, 1))
                send_item(CMD_APPEND_FINISH, 8'($urandom));
            else
                send_item(CMD_FINISH, 8'($urandom));
            sent++;
        end
        drop_valid();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_APPEND;
        in_ch.data_byte = 8'h00;
        error_cnt = 0; item_cnt = 0; digest_cnt = 0; msg_cnt = 0; cycle_cnt = 0;
        rx_idle_en = 1'b1;
        hash_init();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_messages();
        test_block_edges();
        test_random_messages();

        // Drain outstanding digests
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("Covered %0d items in %0d messages, %0d digest words checked.",
                 item_cnt, msg_cnt, digest_cnt);
        if (error_cnt == 0)
            $display("tb_sha1_byte_stream_hash: PASS");
        else
            $display("tb_sha1_byte_stream_hash: FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/sha1_pkg.sv
hdl/sha1_if.sv
hdl/sha1_front.sv
hdl/sha1_core.sv
hdl/sha1_byte_stream_hash.sv
tb/tb_sha1_byte_stream_hash.sv
